// ===== rtl/fmp_pkg.sv =====
package fmp_pkg;

  // Motor and speed limits.
  localparam int NUM_MOTORS    = 4;
  localparam int MAX_SPEED     = 6;
  localparam int PATTERN_COUNT = 7;
  localparam int PATTERN_W     = 16;
  localparam int PHASE_W       = 4;
  localparam int LEVEL_W       = 3;
  localparam int MOTOR_IDX_W   = 2;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;

  typedef logic [PATTERN_W-1:0] pattern_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [PHASE_W-1:0]   phase_t;

  // Request kinds on the input channel.
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SET  = 1'b1
  } kind_t;

  // State held for one motor.
  typedef struct packed {
    logic   rev;
    level_t level;
  } motor_t;

  // Pattern register reset values, one per speed level.
  localparam pattern_t PATTERN_RESET [PATTERN_COUNT] = '{
    16'h0000, 16'h8080, 16'h8888, 16'hAAAA, 16'hEEEE, 16'hFEFE, 16'hFFFF
  };

endpackage

// ===== rtl/fmp_port_builder.sv =====
module fmp_port_builder (
  input  fmp_pkg::pattern_t pattern [fmp_pkg::PATTERN_COUNT],
  input  fmp_pkg::motor_t   motors  [fmp_pkg::NUM_MOTORS],
  input  fmp_pkg::phase_t   phase,
  output logic [7:0]        port_byte
);

  // One on bit per speed level at the current slot; level 7 falls back to the top pattern.
  logic [(1 << fmp_pkg::LEVEL_W)-1:0] slot_on;

  always_comb begin
    for (int l = 0; l < (1 << fmp_pkg::LEVEL_W); l++) begin
      if (l < fmp_pkg::PATTERN_COUNT) begin
        slot_on[l] = pattern[l][phase];
      end else begin
        slot_on[l] = pattern[fmp_pkg::PATTERN_COUNT-1][phase];
      end
    end
  end

  // Each motor drives its on bit, and its reverse bit only while on.
  always_comb begin
    port_byte = 8'h00;
    for (int m = 0; m < fmp_pkg::NUM_MOTORS; m++) begin
      port_byte[4+m] = slot_on[motors[m].level];
      port_byte[m]   = slot_on[motors[m].level] & motors[m].rev;
    end
  end

endmodule

// ===== rtl/four_motor_pattern_pwm.sv =====
// Latency: an accepted request's port byte is registered in the output register and then shown on out_port_byte.
// Throughput: one request per cycle; the only limit is the single output register,
// which takes a new byte in the cycle its current one is taken.
// Reset (rst_n low, synchronous): all motors stopped and forward, PWM phase zero,
// pattern registers at their default values, no result pending.
module four_motor_pattern_pwm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [2:0]                        in_motor_index,
  input  logic signed [7:0]                 in_signed_speed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_port_byte,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fmp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [fmp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [fmp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  fmp_pkg::pattern_t pattern_r [fmp_pkg::PATTERN_COUNT];
  fmp_pkg::motor_t   motors_r  [fmp_pkg::NUM_MOTORS];
  fmp_pkg::motor_t   motors_nxt [fmp_pkg::NUM_MOTORS];
  fmp_pkg::phase_t   phase_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [7:0]        byte_nxt;
  logic              in_fire;
  logic [2:0]        cfg_index;
  logic              cfg_write;
  logic [7:0]        speed_mag;
  fmp_pkg::level_t   speed_level;

  // The output register frees up when empty or when its byte is taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_port_byte = out_byte_r;

  // Configuration port decode; it never stalls.
  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[fmp_pkg::CFG_ADDR_W-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  // Read back the addressed pattern register, zero for unused addresses.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_index < 3'(fmp_pkg::PATTERN_COUNT)) begin
      cfg_prdata = fmp_pkg::CFG_DATA_W'(pattern_r[cfg_index]);
    end
  end

  // Pattern registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= fmp_pkg::PATTERN_RESET;
    end else if (cfg_write && cfg_index < 3'(fmp_pkg::PATTERN_COUNT)) begin
      pattern_r[cfg_index] <= cfg_pwdata[fmp_pkg::PATTERN_W-1:0];
    end
  end

  // Speed magnitude, saturated to the top level; -128 gives 128 and saturates too.
  always_comb begin
    speed_mag = in_signed_speed[7] ? 8'(-in_signed_speed) : 8'(in_signed_speed);
    if (speed_mag > 8'(fmp_pkg::MAX_SPEED)) begin
      speed_level = fmp_pkg::level_t'(fmp_pkg::MAX_SPEED);
    end else begin
      speed_level = speed_mag[fmp_pkg::LEVEL_W-1:0];
    end
  end

  // A set-speed request to a real motor updates it before the byte is built.
  always_comb begin
    motors_nxt = motors_r;
    if (in_fire && in_kind == fmp_pkg::KIND_SET &&
        in_motor_index < 3'(fmp_pkg::NUM_MOTORS)) begin
      motors_nxt[in_motor_index[fmp_pkg::MOTOR_IDX_W-1:0]].rev   = in_signed_speed[7];
      motors_nxt[in_motor_index[fmp_pkg::MOTOR_IDX_W-1:0]].level = speed_level;
    end
  end

  fmp_port_builder u_builder (
    .pattern   (pattern_r),
    .motors    (motors_nxt),
    .phase     (phase_r),
    .port_byte (byte_nxt)
  );

  // Motor state and PWM phase advance once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < fmp_pkg::NUM_MOTORS; m++) begin
        motors_r[m] <= '0;
      end
      phase_r <= '0;
    end else if (in_fire) begin
      motors_r <= motors_nxt;
      phase_r  <= phase_r + fmp_pkg::phase_t'(1);
    end
  end

  // Output register handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output byte payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte_r <= byte_nxt;
    end
  end

endmodule

// ===== rtl/fmp_checker.sv =====
module fmp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_port_byte
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // With no result pending the block always takes a request.
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
    else $error("request refused while output is empty");

  // Every accepted request yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // A reverse bit never shows without its motor's on bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_port_byte[3:0] & ~out_port_byte[7:4]) == 4'h0)
    else $error("reverse bit set for a motor that is off");

  // A stalled result holds its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_port_byte))
    else $error("stalled result changed");

endmodule

bind four_motor_pattern_pwm fmp_checker u_fmp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_port_byte (out_port_byte)
);
